// File: rtl/pcmc_pkg.sv
// ----------------------------------------------------------------------------
// pcmc_pkg
// Shared types, constants and channel expansion tables for the pixel colour
// mask classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmc_pkg;

  // Register indexes (word address / 4)
  localparam logic [2:0] REG_COLOUR_MODE      = 3'd0;
  localparam logic [2:0] REG_CUSTOM_RED       = 3'd1;
  localparam logic [2:0] REG_CUSTOM_GREEN     = 3'd2;
  localparam logic [2:0] REG_CUSTOM_BLUE      = 3'd3;
  localparam logic [2:0] REG_CUSTOM_TOLERANCE = 3'd4;

  // Colour mode codes; unused codes fall back to the luminance band
  localparam logic [2:0] MODE_LUMA   = 3'd0;
  localparam logic [2:0] MODE_SKIN   = 3'd1;
  localparam logic [2:0] MODE_RED    = 3'd2;
  localparam logic [2:0] MODE_GREEN  = 3'd3;
  localparam logic [2:0] MODE_BLUE   = 3'd4;
  localparam logic [2:0] MODE_CUSTOM = 3'd5;

  // Reset values
  localparam logic [2:0] RST_COLOUR_MODE      = MODE_LUMA;
  localparam logic [7:0] RST_CUSTOM_RED       = 8'd220;
  localparam logic [7:0] RST_CUSTOM_GREEN     = 8'd180;
  localparam logic [7:0] RST_CUSTOM_BLUE      = 8'd40;
  localparam logic [7:0] RST_CUSTOM_TOLERANCE = 8'd55;

  // Sum thresholds
  localparam logic [9:0] LUMA_LOW  = 10'd280;
  localparam logic [9:0] LUMA_HIGH = 10'd720;

  // Rule thresholds (9 bits to hold channel + offset)
  localparam logic [8:0] SKIN_R_MIN  = 9'd95;
  localparam logic [8:0] SKIN_G_MIN  = 9'd40;
  localparam logic [8:0] SKIN_B_MIN  = 9'd20;
  localparam logic [8:0] SKIN_MARGIN = 9'd15;
  localparam logic [8:0] RED_MIN     = 9'd140;
  localparam logic [8:0] RED_MARGIN  = 9'd40;
  localparam logic [8:0] GREEN_MIN   = 9'd100;
  localparam logic [8:0] GREEN_MARGIN = 9'd30;
  localparam logic [8:0] BLUE_MIN    = 9'd90;
  localparam logic [8:0] BLUE_MARGIN = 9'd25;

  typedef logic [7:0] lut5_t [32];
  typedef logic [7:0] lut6_t [64];

  // x*255/31, truncated
  function automatic lut5_t build_lut5();
    lut5_t lut;
    for (int i = 0; i < 32; i++) begin
      lut[i] = 8'((i * 255) / 31);
    end
    return lut;
  endfunction

  // x*255/63, truncated
  function automatic lut6_t build_lut6();
    lut6_t lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = 8'((i * 255) / 63);
    end
    return lut;
  endfunction

  localparam lut5_t EXPAND5 = build_lut5();
  localparam lut6_t EXPAND6 = build_lut6();

  typedef struct packed {
    logic [2:0] colour_mode;
    logic [7:0] custom_red;
    logic [7:0] custom_green;
    logic [7:0] custom_blue;
    logic [7:0] custom_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb8_t;

  typedef struct packed {
    logic skin;
    logic red;
    logic green;
    logic blue;
  } rules_t;

  typedef struct packed {
    logic [9:0] sum;
    logic [7:0] diff_r;
    logic [7:0] diff_g;
    logic [7:0] diff_b;
    rules_t     rules;
  } cmp_t;

endpackage

`default_nettype wire

// File: rtl/pcmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcmc_cfg_regs
// APB register file: colour mode and custom colour target / tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmc_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output pcmc_pkg::cfg_t         cfg
);
  import pcmc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_COLOUR_MODE:      cfg_nxt.colour_mode      = pwdata[2:0];
        REG_CUSTOM_RED:       cfg_nxt.custom_red       = pwdata[7:0];
        REG_CUSTOM_GREEN:     cfg_nxt.custom_green     = pwdata[7:0];
        REG_CUSTOM_BLUE:      cfg_nxt.custom_blue      = pwdata[7:0];
        REG_CUSTOM_TOLERANCE: cfg_nxt.custom_tolerance = pwdata[7:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.colour_mode      <= RST_COLOUR_MODE;
      cfg_r.custom_red       <= RST_CUSTOM_RED;
      cfg_r.custom_green     <= RST_CUSTOM_GREEN;
      cfg_r.custom_blue      <= RST_CUSTOM_BLUE;
      cfg_r.custom_tolerance <= RST_CUSTOM_TOLERANCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COLOUR_MODE:      prdata = {29'd0, cfg_r.colour_mode};
      REG_CUSTOM_RED:       prdata = {24'd0, cfg_r.custom_red};
      REG_CUSTOM_GREEN:     prdata = {24'd0, cfg_r.custom_green};
      REG_CUSTOM_BLUE:      prdata = {24'd0, cfg_r.custom_blue};
      REG_CUSTOM_TOLERANCE: prdata = {24'd0, cfg_r.custom_tolerance};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/pcmc_expand.sv
// ----------------------------------------------------------------------------
// pcmc_expand
// Stage 1: split RGB565 and expand each channel to 8 bits by table.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmc_expand (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic            in_valid,
  input  wire logic [15:0]     pixel_word,
  output logic                 valid_r,
  output pcmc_pkg::rgb8_t      rgb_r
);
  import pcmc_pkg::*;

  rgb8_t rgb_nxt;

  always_comb begin
    rgb_nxt.r = EXPAND5[pixel_word[15:11]];
    rgb_nxt.g = EXPAND6[pixel_word[10:5]];
    rgb_nxt.b = EXPAND5[pixel_word[4:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rgb_r <= rgb_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcmc_compare.sv
// ----------------------------------------------------------------------------
// pcmc_compare
// Stage 2: channel sum, distances to the custom colour, dominance rules.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmc_compare (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic            valid_in,
  input  wire pcmc_pkg::rgb8_t rgb,
  input  wire pcmc_pkg::cfg_t  cfg,
  output logic                 valid_r,
  output pcmc_pkg::cmp_t       cmp_r
);
  import pcmc_pkg::*;

  cmp_t       cmp_nxt;
  logic [8:0] r9, g9, b9;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign r9 = {1'b0, rgb.r};
  assign g9 = {1'b0, rgb.g};
  assign b9 = {1'b0, rgb.b};

  always_comb begin
    cmp_nxt.sum    = {2'b00, rgb.r} + {2'b00, rgb.g} + {2'b00, rgb.b};
    cmp_nxt.diff_r = abs_diff(rgb.r, cfg.custom_red);
    cmp_nxt.diff_g = abs_diff(rgb.g, cfg.custom_green);
    cmp_nxt.diff_b = abs_diff(rgb.b, cfg.custom_blue);
    // r > g + 15 implies both r > g and r - g > 15
    cmp_nxt.rules.skin  = (r9 > SKIN_R_MIN) && (g9 > SKIN_G_MIN) && (b9 > SKIN_B_MIN) &&
                          (r9 > g9 + SKIN_MARGIN) && (r9 > b9 + SKIN_MARGIN);
    cmp_nxt.rules.red   = (r9 > RED_MIN) && (r9 > g9 + RED_MARGIN) &&
                          (r9 > b9 + RED_MARGIN);
    cmp_nxt.rules.green = (g9 > GREEN_MIN) && (g9 > r9 + GREEN_MARGIN) &&
                          (g9 > b9 + GREEN_MARGIN);
    cmp_nxt.rules.blue  = (b9 > BLUE_MIN) && (b9 > r9 + BLUE_MARGIN) &&
                          (b9 > g9 + BLUE_MARGIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmp_r <= cmp_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcmc_select.sv
// ----------------------------------------------------------------------------
// pcmc_select
// Stage 3: band and tolerance checks, rule select, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmc_select (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic            valid_in,
  input  wire pcmc_pkg::cmp_t  cmp,
  input  wire pcmc_pkg::cfg_t  cfg,
  output logic                 valid_r,
  output logic                 mask_hit_r,
  output logic                 bright_r
);
  import pcmc_pkg::*;

  logic mask_hit_nxt;
  logic bright_nxt;
  logic luma_hit;
  logic custom_hit;

  assign luma_hit   = (cmp.sum > LUMA_LOW) && (cmp.sum < LUMA_HIGH);
  assign custom_hit = (cmp.diff_r <= cfg.custom_tolerance) &&
                      (cmp.diff_g <= cfg.custom_tolerance) &&
                      (cmp.diff_b <= cfg.custom_tolerance);
  assign bright_nxt = cmp.sum > LUMA_HIGH;

  always_comb begin
    unique case (cfg.colour_mode)
      MODE_SKIN:   mask_hit_nxt = cmp.rules.skin;
      MODE_RED:    mask_hit_nxt = cmp.rules.red;
      MODE_GREEN:  mask_hit_nxt = cmp.rules.green;
      MODE_BLUE:   mask_hit_nxt = cmp.rules.blue;
      MODE_CUSTOM: mask_hit_nxt = custom_hit;
      default:     mask_hit_nxt = luma_hit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mask_hit_r <= mask_hit_nxt;
      bright_r   <= bright_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pixel_colour_mask_classifier_core.sv
// ----------------------------------------------------------------------------
// pixel_colour_mask_classifier_core
// RGB565 colour threshold segmenter: one mask hit and one bright flag per
// pixel word, three-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                  | word
//  ---------+----------------------------------------+---------------------------
//  input    | in_valid / in_stall / in_pixel_word    | RGB565 pixel
//  result   | out_valid / out_stall / out_mask_hit,  | mask hit, bright flag
//           | out_bright_pixel                       |
//  config   | cfg_psel .. cfg_pready (APB)           | 5 regs at 0x00..0x10
//
//  One word per clock sustained while no result waits under out_stall; an accepted
//  word reaches out_valid via expand table -> sum/compare -> rule select + output register.
//  The whole pipeline holds while a result waits under out_stall; in_stall is
//  raised only then. Empty stages carry valid low, so nothing is lost or
//  repeated. Synchronous active-low reset clears stage valids and loads
//  register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_colour_mask_classifier_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pixel_word,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_mask_hit,
  output logic             out_bright_pixel,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import pcmc_pkg::*;

  cfg_t   cfg;
  rgb8_t  s1_rgb;
  cmp_t   s2_cmp;
  logic   s1_valid;
  logic   s2_valid;
  logic   advance;

  // Global hold: only the output register can block.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  pcmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Stage 1: channel expansion
  pcmc_expand u_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_valid   (in_valid),
    .pixel_word (in_pixel_word),
    .valid_r    (s1_valid),
    .rgb_r      (s1_rgb)
  );

  // Stage 2: sum, custom distances, dominance rules
  pcmc_compare u_compare (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .valid_in (s1_valid),
    .rgb      (s1_rgb),
    .cfg      (cfg),
    .valid_r  (s2_valid),
    .cmp_r    (s2_cmp)
  );

  // Stage 3: mode select into the output register
  pcmc_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .valid_in   (s2_valid),
    .cmp        (s2_cmp),
    .cfg        (cfg),
    .valid_r    (out_valid),
    .mask_hit_r (out_mask_hit),
    .bright_r   (out_bright_pixel)
  );

endmodule

`default_nettype wire

// File: rtl/pcmc_checker.sv
// ----------------------------------------------------------------------------
// pcmc_checker
// Port-level checks for the classifier core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_mask_hit,
  input wire logic out_bright_pixel,
  input wire logic cfg_pready
);

  // Input held back only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  // Accepted word reaches the output when the output side keeps draining
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach the output in three cycles");

  // Result held under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_mask_hit) && $stable(out_bright_pixel)))
    else $error("stalled result changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind pixel_colour_mask_classifier_core pcmc_checker u_pcmc_checker (.*);

`default_nettype wire

// File: tb/pcmc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmc_result_checker
// Passive scoreboard for the pixel colour mask classifier: mirrors register
// writes off the config bus, predicts mask hit and bright flag for every pixel
// word taken in, and checks each result word in order.
// ----------------------------------------------------------------------------

module pcmc_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_pixel_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_mask_hit,
  input  logic        out_bright_pixel,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          words_in_flight
);
  import pcmc_pkg::*;

  localparam int BAND_LOW    = 280;
  localparam int BAND_HIGH   = 720;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [15:0] pixel;
    logic        mask_hit;
    logic        bright_pixel;
  } pixel_verdict_t;

  logic [2:0] mode_q;
  logic [7:0] tgt_red;
  logic [7:0] tgt_green;
  logic [7:0] tgt_blue;
  logic [7:0] tgt_tol;

  pixel_verdict_t pending_verdicts[$];

  function automatic int chan_dist(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // 565 -> 888 by truncating scale, then the selected colour rule
  function automatic pixel_verdict_t classify_pixel(input logic [15:0] px);
    int r;
    int g;
    int b;
    int s;
    pixel_verdict_t v;
    r = int'(px[15:11]) * 255 / 31;
    g = int'(px[10:5]) * 255 / 63;
    b = int'(px[4:0]) * 255 / 31;
    s = r + g + b;
    v.pixel = px;
    case (mode_q)
      MODE_SKIN: v.mask_hit = r > 95 && g > 40 && b > 20 && r > g && r > b &&
                              (r - g) > 15 && (r - b) > 15;
      MODE_RED:   v.mask_hit = r > 140 && r > g + 40 && r > b + 40;
      MODE_GREEN: v.mask_hit = g > 100 && g > r + 30 && g > b + 30;
      MODE_BLUE:  v.mask_hit = b > 90 && b > r + 25 && b > g + 25;
      MODE_CUSTOM: v.mask_hit = chan_dist(r, int'(tgt_red)) <= int'(tgt_tol) &&
                                chan_dist(g, int'(tgt_green)) <= int'(tgt_tol) &&
                                chan_dist(b, int'(tgt_blue)) <= int'(tgt_tol);
      default: v.mask_hit = s > BAND_LOW && s < BAND_HIGH;
    endcase
    v.bright_pixel = s > BAND_HIGH;
    return v;
  endfunction

  initial begin
    fail_count      = 0;
    words_in_flight = 0;
  end

  always @(posedge clk) begin : monitor
    pixel_verdict_t want;
    if (!rst_n) begin
      mode_q    <= RST_COLOUR_MODE;
      tgt_red   <= RST_CUSTOM_RED;
      tgt_green <= RST_CUSTOM_GREEN;
      tgt_blue  <= RST_CUSTOM_BLUE;
      tgt_tol   <= RST_CUSTOM_TOLERANCE;
      pending_verdicts.delete();
      words_in_flight = 0;
    end else begin
      // config writes land only while idle, so a plain NBA shadow is enough
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_COLOUR_MODE:      mode_q    <= cfg_pwdata[2:0];
          REG_CUSTOM_RED:       tgt_red   <= cfg_pwdata[7:0];
          REG_CUSTOM_GREEN:     tgt_green <= cfg_pwdata[7:0];
          REG_CUSTOM_BLUE:      tgt_blue  <= cfg_pwdata[7:0];
          REG_CUSTOM_TOLERANCE: tgt_tol   <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: result word with nothing pending (hit %0b bright %0b)",
                     $time, out_mask_hit, out_bright_pixel);
          fail_count = fail_count + 1;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_mask_hit !== want.mask_hit || out_bright_pixel !== want.bright_pixel) begin
            if (fail_count < REPORT_MAX)
              $display("%0t: pixel %h: mask_hit exp %0b got %0b, bright exp %0b got %0b",
                       $time, want.pixel, want.mask_hit, out_mask_hit,
                       want.bright_pixel, out_bright_pixel);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_verdicts.push_back(classify_pixel(in_pixel_word));
      words_in_flight = pending_verdicts.size();
    end
  end

endmodule

// File: tb/tb_pixel_colour_mask_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_colour_mask_classifier_core
// Drives pixel words and register writes into the colour mask classifier;
// a side checker predicts and compares every result word. Directed sweep of
// all mode codes first, then random phases with varied idling on both sides.
// ----------------------------------------------------------------------------

module tb_pixel_colour_mask_classifier_core;
  import pcmc_pkg::*;

  // Run shape
  localparam int PHASES          = 9;
  localparam int WORDS_PER_PHASE = 142;
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no word moving
  localparam int DRAIN_CYCLES    = 10;    // pipeline is three deep

  // Mode codes with no rule of their own; block treats them as luma band
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  // First register index past the map; writes there must be dropped
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;

  // Handy pixels for the directed sweep
  localparam logic [15:0] PX_BLACK  = 16'h0000;
  localparam logic [15:0] PX_WHITE  = 16'hFFFF;
  localparam logic [15:0] PX_RED    = 16'hF800;
  localparam logic [15:0] PX_GREEN  = 16'h07E0;
  localparam logic [15:0] PX_BLUE   = 16'h001F;
  localparam logic [15:0] PX_GREY   = {5'd16, 6'd32, 5'd16};  // sum 391, in band
  localparam logic [15:0] PX_SKIN   = {5'd28, 6'd36, 5'd12};  // 230/145/98
  localparam logic [15:0] PX_AMBER  = {5'd27, 6'd45, 5'd5};   // 222/182/41, near reset target

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [15:0] in_pixel_word    = '0;
  logic        out_valid;
  logic        out_stall        = 1'b1;
  logic        out_mask_hit;
  logic        out_bright_pixel;
  logic        cfg_psel         = 1'b0;
  logic        cfg_penable      = 1'b0;
  logic        cfg_pwrite       = 1'b0;
  logic [4:0]  cfg_paddr        = '0;
  logic [31:0] cfg_pwdata       = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int words_in_flight;

  // idle odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // what the stimulus last programmed; steers the custom-colour pixels
  logic [2:0] cur_mode;
  int         cur_red;
  int         cur_green;
  int         cur_blue;

  // handshake flags, registered at the rising edge and read at the falling one
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;
  int   quiet_cycles = 0;

  pixel_colour_mask_classifier_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_word    (in_pixel_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mask_hit     (out_mask_hit),
    .out_bright_pixel (out_bright_pixel),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  pcmc_result_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_word    (in_pixel_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mask_hit     (out_mask_hit),
    .out_bright_pixel (out_bright_pixel),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_pready       (cfg_pready),
    .fail_count       (fail_count),
    .words_in_flight  (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken  <= in_valid && !in_stall;
    cfg_taken <= cfg_psel && cfg_penable && cfg_pready;
  end

  // Receiver back-pressure, re-rolled every cycle
  always @(negedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: any word moving on either channel resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // All tasks are entered and left at a falling edge.

  // Optional idle gap, then hold the word until the block takes it.
  // Valid stays high on return so back-to-back words need no second NBA.
  task automatic send_pixel(input logic [15:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_word <= px;
    do @(negedge clk); while (!in_taken);
  endtask

  // Sender goes quiet until every result word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
  endtask

  // APB write: setup then access. psel is left high so writes chain;
  // release_bus() closes the burst.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic release_bus();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Full register load; upper bits carry junk the block must drop, and a
  // write to an unmapped index must change nothing.
  task automatic load_regs(input logic [2:0] mode, input int red, input int green,
                           input int blue, input int tol);
    wait_drained();
    write_reg(REG_COLOUR_MODE, ($urandom & 32'hFFFF_FFF8) | 32'(mode));
    write_reg(REG_CUSTOM_RED, ($urandom & 32'hFFFF_FF00) | 32'(red));
    write_reg(REG_CUSTOM_GREEN, ($urandom & 32'hFFFF_FF00) | 32'(green));
    write_reg(REG_CUSTOM_BLUE, ($urandom & 32'hFFFF_FF00) | 32'(blue));
    write_reg(REG_CUSTOM_TOLERANCE, ($urandom & 32'hFFFF_FF00) | 32'(tol));
    write_reg(REG_SPARE_FIRST + 3'($urandom_range(2)), $urandom);
    release_bus();
    cur_mode  = mode;
    cur_red   = red;
    cur_green = green;
    cur_blue  = blue;
  endtask

  // Channel code close to an 8-bit target level, jittered by +-2 steps
  function automatic int near_code(input int level, input int top);
    int c;
    c = (level * top + 127) / 255 + int'($urandom_range(4)) - 2;
    if (c < 0) c = 0;
    if (c > top) c = top;
    return c;
  endfunction

  // Custom mode rarely hits on uniform pixels, so most of those words aim
  // near the programmed target; everything else is uniform.
  function automatic logic [15:0] pick_pixel();
    int r5;
    int g6;
    int b5;
    if (cur_mode == MODE_CUSTOM && $urandom_range(9) < 6) begin
      r5 = near_code(cur_red, 31);
      g6 = near_code(cur_green, 63);
      b5 = near_code(cur_blue, 31);
      return {r5[4:0], g6[5:0], b5[4:0]};
    end
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    logic [15:0] hit_px;
    logic [2:0]  mode;
    int          red;
    int          green;
    int          blue;
    int          tol;

    cur_mode  = RST_COLOUR_MODE;
    cur_red   = RST_CUSTOM_RED;
    cur_green = RST_CUSTOM_GREEN;
    cur_blue  = RST_CUSTOM_BLUE;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sweep: every mode code incl. the two spare ones, each with
    // black, white and a pixel that should hit that rule. Custom runs on the
    // reset target so register defaults get exercised too.
    send_idle_pct = 11;
    recv_idle_pct = 61;
    for (int m = 0; m < 8; m++) begin
      mode = 3'(m);
      if (m != 0) begin
        wait_drained();
        write_reg(REG_COLOUR_MODE, 32'(mode));
        release_bus();
        cur_mode = mode;
      end
      case (mode)
        MODE_SKIN:   hit_px = PX_SKIN;
        MODE_RED:    hit_px = PX_RED;
        MODE_GREEN:  hit_px = PX_GREEN;
        MODE_BLUE:   hit_px = PX_BLUE;
        MODE_CUSTOM: hit_px = PX_AMBER;
        default:     hit_px = PX_GREY;
      endcase
      send_pixel(PX_BLACK);
      send_pixel(PX_WHITE);
      send_pixel(hit_px);
    end

    // Random phases. Idling: light sender / heavy receiver, then swapped,
    // then flat out.
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 3) ? 11 : (p < 6) ? 61 : 0;
      recv_idle_pct = (p < 3) ? 61 : (p < 6) ? 11 : 0;
      red   = $urandom_range(255);
      green = $urandom_range(255);
      blue  = $urandom_range(255);
      tol   = $urandom_range(80);
      case (p)
        0: begin  // exact target, zero tolerance
          mode = MODE_CUSTOM; red = 222; green = 182; blue = 41; tol = 0;
        end
        1: mode = MODE_RED;
        2: mode = MODE_SKIN;
        3: begin  // extreme targets, widest tolerance: everything matches
          mode = MODE_CUSTOM; red = 0; green = 255; blue = 0; tol = 255;
        end
        4: mode = MODE_GREEN;
        5: mode = MODE_BLUE;
        6: mode = MODE_SPARE6;
        7: mode = MODE_CUSTOM;
        default: mode = MODE_SPARE7;
      endcase
      load_regs(mode, red, green, blue, tol);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // mid-phase, let the pipe run completely dry once
        if (i == WORDS_PER_PHASE / 2) wait_drained();
        send_pixel(pick_pixel());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pcmc_pkg.sv
rtl/pcmc_cfg_regs.sv
rtl/pcmc_expand.sv
rtl/pcmc_compare.sv
rtl/pcmc_select.sv
rtl/pixel_colour_mask_classifier_core.sv
rtl/pcmc_checker.sv
tb/pcmc_result_checker.sv
tb/tb_pixel_colour_mask_classifier_core.sv
